>>> rtl/blm_pkg.sv
// Shared types, constants and helper functions of the battery level monitor.
`default_nettype none

package blm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int MV_W      = 13;
    localparam int PCT_W     = 7;
    localparam int LEVEL_W   = 7;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam int DIV_DVD_W = 20;
    localparam int DIV_DVS_W = 13;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(0);
    localparam int               STEP_SIZE = 10;
    localparam int               STEP_NUM  = 10;

    localparam logic [MV_W-1:0]    FULL_MV_RST     = MV_W'(4200);
    localparam logic [MV_W-1:0]    EMPTY_MV_RST    = MV_W'(3500);
    localparam logic [LEVEL_W-1:0] BLINK_LEVEL_RST = LEVEL_W'(5);
    localparam logic [LEVEL_W-1:0] SLEEP_LEVEL_RST = LEVEL_W'(3);
    localparam logic [PCT_W-1:0]   LAST_STEP_RST   = PCT_W'(100);

    localparam logic [1:0] REG_FULL_MV     = 2'd0;
    localparam logic [1:0] REG_EMPTY_MV    = 2'd1;
    localparam logic [1:0] REG_BLINK_LEVEL = 2'd2;
    localparam logic [1:0] REG_SLEEP_LEVEL = 2'd3;

    typedef struct packed {
        logic [MV_W-1:0]    full_mv;
        logic [MV_W-1:0]    empty_mv;
        logic [LEVEL_W-1:0] blink_level;
        logic [LEVEL_W-1:0] sleep_level;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

    // ((pct + 1) / 10) * 10 for pct in 0..127
    function automatic logic [PCT_W-1:0] pct_step(input logic [PCT_W-1:0] pct);
        logic [PCT_W:0]   inc;
        logic [PCT_W-1:0] step;
        inc  = {1'b0, pct} + (PCT_W + 1)'(1);
        step = '0;
        for (int k = 1; k <= STEP_NUM + 2; k++) begin
            if (inc >= (PCT_W + 1)'(k * STEP_SIZE))
            begin
                step = PCT_W'(k * STEP_SIZE);
            end
        end
        return step;
    endfunction

endpackage

`default_nettype wire

>>> rtl/blm_cfg_regs.sv
// APB configuration register file of the battery level monitor.
`default_nettype none

module blm_cfg_regs
    import blm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_mv     <= FULL_MV_RST;
            cfg_reg.empty_mv    <= EMPTY_MV_RST;
            cfg_reg.blink_level <= BLINK_LEVEL_RST;
            cfg_reg.sleep_level <= SLEEP_LEVEL_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FULL_MV:     cfg_reg.full_mv     <= pwdata[MV_W-1:0];
                REG_EMPTY_MV:    cfg_reg.empty_mv    <= pwdata[MV_W-1:0];
                REG_BLINK_LEVEL: cfg_reg.blink_level <= pwdata[LEVEL_W-1:0];
                REG_SLEEP_LEVEL: cfg_reg.sleep_level <= pwdata[LEVEL_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FULL_MV:     prdata = APB_DW'(cfg_reg.full_mv);
            REG_EMPTY_MV:    prdata = APB_DW'(cfg_reg.empty_mv);
            REG_BLINK_LEVEL: prdata = APB_DW'(cfg_reg.blink_level);
            REG_SLEEP_LEVEL: prdata = APB_DW'(cfg_reg.sleep_level);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/blm_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module blm_divider
    import blm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_DVS_W:0]   rem_sh;
    logic [DIV_DVS_W:0]   rem_sub;
    logic                 ge;

    assign rem_sh  = {rem_reg, quo_reg[DIV_DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_DVD_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
            quo_next = {quo_reg[DIV_DVD_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/battery_level_monitor.sv
// Top level of the battery level monitor: sample gathering, sequencer and status flags.
//
// A sample word that does not complete a group of SAMPLE_COUNT is taken while the block
// is idle and added to the running sum. The last sample of a group starts a measurement.
// The AVG state forms the group average by a constant reciprocal multiply and keeps it
// doubled in mv. The PCT_PREP state checks the calibration. When full_mv is above
// empty_mv and the voltage is above empty_mv, the divider then forms the percentage and
// flags completion. The FINISH state then loads the result word into the output
// register, waiting while result_stall still holds the previous result. sample_stall
// stays high until the result word is loaded. Configuration writes must only be made
// while the block is idle.
`default_nettype none

module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int SAMPLE_COUNT = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready,

    input  wire logic                sample_valid,
    output logic                     sample_stall,
    input  wire logic [SAMPLE_W-1:0] sample_mv,

    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic      [MV_W-1:0]     battery_mv,
    output logic      [PCT_W-1:0]    percentage,
    output logic                     priming,
    output logic                     led_on,
    output logic                     fast_poll,
    output logic                     sleep_request,
    output logic                     level_event
);

    localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLE_COUNT);
    localparam int CNT_W    = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int RECIP_SH = SUM_W + CNT_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_AVG      = 5'b00010,
        ST_PCT_PREP = 5'b00100,
        ST_PCT_DIV  = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t           state_reg, state_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [MV_W-1:0]  mv_reg, mv_next;
    logic [PCT_W-1:0] pct_reg, pct_next;
    logic             primed_reg, primed_next;
    logic [MV_W-1:0]  prev_mv_reg, prev_mv_next;
    logic [PCT_W-1:0] prev_pct_reg, prev_pct_next;
    logic [PCT_W-1:0] last_step_reg, last_step_next;
    logic             blink_reg, blink_next;

    logic             res_valid_reg, res_valid_next;
    logic [MV_W-1:0]  res_mv_reg, res_mv_next;
    logic [PCT_W-1:0] res_pct_reg, res_pct_next;
    logic             res_prim_reg, res_prim_next;
    logic             res_led_reg, res_led_next;
    logic             res_fast_reg, res_fast_next;
    logic             res_sleep_reg, res_sleep_next;
    logic             res_event_reg, res_event_next;

    logic             sample_take;
    logic             result_take;
    logic [SUM_W-1:0] sum_add;
    logic [PROD_W-1:0] avg_prod;
    logic [MV_W-1:0]  span_mv;
    logic [MV_W-1:0]  above_mv;
    logic [DIV_DVD_W-1:0] above_x100;
    logic             low_level;
    logic [PCT_W-1:0] step;

    blm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_take  = sample_valid && !sample_stall;
    assign result_take  = res_valid_reg && !result_stall;

    assign sum_add    = sum_reg + SUM_W'(sample_mv);
    assign avg_prod   = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign span_mv    = cfg.full_mv - cfg.empty_mv;
    assign above_mv   = mv_reg - cfg.empty_mv;
    assign above_x100 = (DIV_DVD_W'(above_mv) << 6) + (DIV_DVD_W'(above_mv) << 5)
                      + (DIV_DVD_W'(above_mv) << 2);
    assign low_level  = (pct_reg <= cfg.blink_level);
    assign step       = pct_step(pct_reg);

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        mv_next         = mv_reg;
        pct_next        = pct_reg;
        primed_next     = primed_reg;
        prev_mv_next    = prev_mv_reg;
        prev_pct_next   = prev_pct_reg;
        last_step_next  = last_step_reg;
        blink_next      = blink_reg;
        res_valid_next  = res_valid_reg && !result_take;
        res_mv_next     = res_mv_reg;
        res_pct_next    = res_pct_reg;
        res_prim_next   = res_prim_reg;
        res_led_next    = res_led_reg;
        res_fast_next   = res_fast_reg;
        res_sleep_next  = res_sleep_reg;
        res_event_next  = res_event_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    if (count_reg == CNT_W'(SAMPLE_COUNT - 1))
                    begin
                        sum_next   = sum_add;
                        count_next = '0;
                        state_next = ST_AVG;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_AVG:
            begin
                mv_next    = {avg_prod[RECIP_SH +: MV_W-1], 1'b0};
                sum_next   = '0;
                state_next = ST_PCT_PREP;
            end
            ST_PCT_PREP:
            begin
                if (cfg.full_mv <= cfg.empty_mv)
                begin
                    pct_next   = (mv_reg >= cfg.full_mv) ? PCT_FULL : PCT_EMPTY;
                    state_next = ST_FINISH;
                end
                else if (mv_reg <= cfg.empty_mv)
                begin
                    pct_next   = PCT_EMPTY;
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = above_x100;
                    div_req.divisor  = span_mv;
                    state_next       = ST_PCT_DIV;
                end
            end
            ST_PCT_DIV:
            begin
                if (div_rsp.done)
                begin
                    pct_next   = (div_rsp.quotient > DIV_DVD_W'(PCT_FULL))
                               ? PCT_FULL : div_rsp.quotient[PCT_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next = 1'b1;
                    res_mv_next    = mv_reg;
                    res_pct_next   = pct_reg;
                    res_prim_next  = !primed_reg;
                    res_led_next   = 1'b0;
                    res_fast_next  = 1'b0;
                    res_sleep_next = 1'b0;
                    res_event_next = 1'b0;
                    if (!primed_reg)
                    begin
                        primed_next    = 1'b1;
                        last_step_next = LAST_STEP_RST;
                    end
                    else
                    begin
                        if (low_level)
                        begin
                            res_fast_next  = 1'b1;
                            res_led_next   = blink_reg;
                            blink_next     = !blink_reg;
                            res_sleep_next = (pct_reg <= cfg.sleep_level);
                        end
                        if (mv_reg <= prev_mv_reg && prev_pct_reg >= step
                            && pct_reg < step && step < last_step_reg)
                        begin
                            last_step_next = step;
                            res_event_next = 1'b1;
                        end
                    end
                    prev_mv_next  = mv_reg;
                    prev_pct_next = pct_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            primed_reg    <= 1'b0;
            prev_mv_reg   <= '0;
            prev_pct_reg  <= '0;
            last_step_reg <= LAST_STEP_RST;
            blink_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            primed_reg    <= primed_next;
            prev_mv_reg   <= prev_mv_next;
            prev_pct_reg  <= prev_pct_next;
            last_step_reg <= last_step_next;
            blink_reg     <= blink_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg        <= mv_next;
        pct_reg       <= pct_next;
        res_mv_reg    <= res_mv_next;
        res_pct_reg   <= res_pct_next;
        res_prim_reg  <= res_prim_next;
        res_led_reg   <= res_led_next;
        res_fast_reg  <= res_fast_next;
        res_sleep_reg <= res_sleep_next;
        res_event_reg <= res_event_next;
    end

    assign result_valid  = res_valid_reg;
    assign battery_mv    = res_mv_reg;
    assign percentage    = res_pct_reg;
    assign priming       = res_prim_reg;
    assign led_on        = res_led_reg;
    assign fast_poll     = res_fast_reg;
    assign sleep_request = res_sleep_reg;
    assign level_event   = res_event_reg;

endmodule

`default_nettype wire

>>> bench/battery_level_monitor_tb.sv
// Self-checking bench: battery level monitor driven through its sample, result and APB ports.
`timescale 1ns / 100ps

module battery_level_monitor_tb;
    import blm_pkg::*;

    localparam int SAMPLES       = 4;
    localparam int SETTLE_CYCLES = 64;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int PHASE_WORDS   = 110;
    localparam int TAP_MAX       = 4095;

    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic [PCT_W-1:0] pct;
        logic             prim;
        logic             led;
        logic             fast;
        logic             sleep;
        logic             ev;
    } status_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [APB_AW-1:0]   paddr        = '0;
    logic [APB_DW-1:0]   pwdata       = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample_mv    = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [MV_W-1:0]     battery_mv;
    logic [PCT_W-1:0]    percentage;
    logic                priming;
    logic                led_on;
    logic                fast_poll;
    logic                sleep_request;
    logic                level_event;

    logic [MV_W-1:0]    cal_full     = FULL_MV_RST;
    logic [MV_W-1:0]    cal_empty    = EMPTY_MV_RST;
    logic [LEVEL_W-1:0] lvl_blink    = BLINK_LEVEL_RST;
    logic [LEVEL_W-1:0] lvl_sleep    = SLEEP_LEVEL_RST;
    int                 acc_sum      = 0;
    int                 acc_count    = 0;
    logic               have_primed  = 1'b0;
    logic [MV_W-1:0]    last_mv      = '0;
    logic [PCT_W-1:0]   last_pct     = '0;
    logic [PCT_W-1:0]   step_mark    = LAST_STEP_RST;
    logic               blink_toggle = 1'b0;

    status_t pending_status[$];
    int      mismatch_count = 0;
    int      rx_wait        = 0;
    logic    tx_steady      = 1'b1;
    logic    rx_steady      = 1'b1;

    battery_level_monitor #(.SAMPLE_COUNT(SAMPLES)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_mv     (sample_mv),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .battery_mv    (battery_mv),
        .percentage    (percentage),
        .priming       (priming),
        .led_on        (led_on),
        .fast_poll     (fast_poll),
        .sleep_request (sleep_request),
        .level_event   (level_event)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [PCT_W-1:0] soc_percent(input logic [MV_W-1:0] mv);
        int q;
        if (cal_full <= cal_empty)
        begin
            return (mv >= cal_full) ? PCT_FULL : PCT_EMPTY;
        end
        if (mv <= cal_empty)
        begin
            return PCT_EMPTY;
        end
        q = (int'(mv - cal_empty) * int'(PCT_FULL)) / int'(cal_full - cal_empty);
        return (q > int'(PCT_FULL)) ? PCT_FULL : PCT_W'(q);
    endfunction

    function automatic logic [SAMPLE_W-1:0] tap_clip(input int v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > TAP_MAX)
        begin
            return SAMPLE_W'(TAP_MAX);
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        if ($urandom_range(0, 4) == 0)
        begin
            return LEVEL_W'($urandom_range(101, 127));
        end
        return LEVEL_W'($urandom_range(0, 100));
    endfunction

    task automatic predict_status(input logic [SAMPLE_W-1:0] word);
        status_t w;
        int      step;
        acc_sum   += int'(word);
        acc_count += 1;
        if (acc_count < SAMPLES)
        begin
            return;
        end
        w         = '0;
        w.mv      = MV_W'(2 * (acc_sum / SAMPLES));
        acc_sum   = 0;
        acc_count = 0;
        w.pct     = soc_percent(w.mv);
        if (!have_primed)
        begin
            have_primed = 1'b1;
            w.prim      = 1'b1;
            step_mark   = LAST_STEP_RST;
        end
        else
        begin
            if (w.pct <= lvl_blink)
            begin
                w.fast       = 1'b1;
                w.led        = blink_toggle;
                blink_toggle = !blink_toggle;
                w.sleep      = (w.pct <= lvl_sleep);
            end
            if (w.mv <= last_mv)
            begin
                step = ((int'(w.pct) + 1) / STEP_SIZE) * STEP_SIZE;
                if (int'(last_pct) >= step && int'(w.pct) < step && step < int'(step_mark))
                begin
                    step_mark = PCT_W'(step);
                    w.ev      = 1'b1;
                end
            end
        end
        last_mv  = w.mv;
        last_pct = w.pct;
        pending_status.push_back(w);
    endtask

    always @(posedge clk)
    begin
        status_t want;
        status_t seen;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                seen = '{battery_mv, percentage, priming, led_on, fast_poll,
                         sleep_request, level_event};
                if (pending_status.size() == 0)
                begin
                    $display("%0t ns: unexpected status word mv=%0d pct=%0d", $time,
                             battery_mv, percentage);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (seen !== want)
                    begin
                        $display("%0t ns: status mismatch, expected mv=%0d pct=%0d prim=%0b",
                                 $time, want.mv, want.pct, want.prim,
                                 " led=%0b fast=%0b sleep=%0b event=%0b,",
                                 want.led, want.fast, want.sleep, want.ev,
                                 " actual mv=%0d pct=%0d prim=%0b led=%0b",
                                 seen.mv, seen.pct, seen.prim, seen.led,
                                 " fast=%0b sleep=%0b event=%0b",
                                 seen.fast, seen.sleep, seen.ev);
                        mismatch_count++;
                    end
                end
                rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
                result_stall <= (rx_wait != 0);
            end
            else if (result_valid && rx_wait > 0)
            begin
                rx_wait--;
                result_stall <= (rx_wait != 0);
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] word);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_mv    <= word;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        predict_status(word);
    endtask

    task automatic send_group(input int tap, input int spread);
        for (int k = 0; k < SAMPLES; k++)
        begin
            send_sample(tap_clip(tap + $urandom_range(0, 2 * spread) - spread));
        end
    endtask

    task automatic release_sender();
        sample_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        release_sender();
        while (pending_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({reg_idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_FULL_MV:     cal_full  = value[MV_W-1:0];
            REG_EMPTY_MV:    cal_empty = value[MV_W-1:0];
            REG_BLINK_LEVEL: lvl_blink = value[LEVEL_W-1:0];
            REG_SLEEP_LEVEL: lvl_sleep = value[LEVEL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_calibration(input int full, input int empty, input int blink,
                                   input int sleep_lvl);
        wait_idle();
        apb_write(REG_FULL_MV, APB_DW'(full));
        apb_write(REG_EMPTY_MV, APB_DW'(empty));
        apb_write(REG_BLINK_LEVEL, APB_DW'(blink));
        apb_write(REG_SLEEP_LEVEL, APB_DW'(sleep_lvl));
        @(posedge clk);
    endtask

    task automatic test_priming_and_range();
        send_group(TAP_MAX, 0);
        send_group(2062, 0);
        send_group(1782, 0);
        for (int k = 0; k < SAMPLES; k++)
        begin
            send_sample(SAMPLE_W'(k));
        end
    endtask

    task automatic test_uncalibrated();
        set_calibration(3000, 3000, BLINK_LEVEL_RST, SLEEP_LEVEL_RST);
        send_group(1500, 0);
    endtask

    task automatic test_level_order();
        set_calibration(8190, 0, 10, 50);
        send_group(1000, 0);
        set_calibration(0, 8190, 127, 127);
        send_group(TAP_MAX, 0);
    endtask

    task automatic test_random_discharge(input logic steady_tx, input logic steady_rx);
        int sent;
        int full;
        int empty;
        int hi;
        int lo;
        int tap;
        int stride;
        int pick;
        if ($urandom_range(0, 6) == 0)
        begin
            full  = $urandom_range(0, 8190);
            empty = $urandom_range(full, 8190);
        end
        else
        begin
            empty = $urandom_range(0, 7000);
            full  = $urandom_range(empty + 1, 8190);
        end
        set_calibration(full, empty, pick_level(), pick_level());
        tx_steady = steady_tx;
        rx_steady = steady_rx;
        hi     = ((full > empty) ? full : empty) / 2 + 24;
        lo     = ((full > empty) ? empty : full) / 2 - 24;
        stride = (hi - lo) / 40 + 1;
        tap    = hi;
        sent   = 0;
        while (sent < PHASE_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                for (int k = 0; k < SAMPLES; k++)
                begin
                    send_sample(SAMPLE_W'($urandom_range(0, TAP_MAX)));
                end
            end
            else
            begin
                if (pick < 25)
                begin
                    tap = hi;
                end
                send_group(tap, 2);
                tap -= $urandom_range(0, stride);
                if (tap < lo)
                begin
                    tap = hi;
                end
            end
            sent += SAMPLES;
            if ($urandom_range(0, 31) == 0)
            begin
                wait_idle();
            end
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_priming_and_range();
        test_uncalibrated();
        test_level_order();
        test_random_discharge(1'b0, 1'b0);
        test_random_discharge(1'b1, 1'b0);
        test_random_discharge(1'b0, 1'b1);
        test_random_discharge(1'b1, 1'b1);
        test_random_discharge(1'b0, 1'b0);
        wait_idle();
        if (mismatch_count == 0 && pending_status.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
